### src/mpso_pkg.sv
// Shared types, constants and helper functions for the perturb-and-observe tracker.
// No dependencies; every other file refers to this package by scoped names.
package mpso_pkg;

  localparam int ADC_BITS   = 12;
  localparam int PWM_PERIOD = 1000;
  localparam int DUTY_W     = 16;
  localparam int INC_W      = 14;
  localparam int PWR_W      = 25;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      = DUTY_W + 2;
  localparam int PROD_W     = (2 * ADC_BITS + 2 > PWR_W) ? 2 * ADC_BITS + 2 : PWR_W;
  localparam int CMP_PROD_W = 2 * DUTY_W;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURR_ZERO = 2'd3;

  localparam logic [DUTY_W-1:0]   RST_DUTY_LOW  = 16'd36045;
  localparam logic [DUTY_W-1:0]   RST_DUTY_HIGH = 16'd49152;
  localparam logic [INC_W-1:0]    RST_DUTY_STEP = 14'd328;
  localparam logic [ADC_BITS-1:0] RST_CURR_ZERO = ADC_BITS'(1729);
  localparam logic [DUTY_W-1:0]   RST_DUTY      = 16'd36045;

  localparam logic [MODE_W-1:0] RUN_IDLE    = 2'd0;
  localparam logic [MODE_W-1:0] RUN_SWEEP   = 2'd1;
  localparam logic [MODE_W-1:0] RUN_CENTRE  = 2'd2;
  localparam logic [MODE_W-1:0] RUN_PERTURB = 2'd3;

  typedef logic signed [PWR_W-1:0] power_t;

  typedef enum logic [1:0] {
    KIND_HOLD   = 2'd0,
    KIND_START  = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SWEEP   = 4'b0010,
    ST_CENTRE  = 4'b0100,
    ST_PERTURB = 4'b1000
  } state_t;

  typedef struct packed {
    kind_t  kind;
    power_t power;
  } entry_t;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty_low;
    logic [DUTY_W-1:0]   duty_high;
    logic [INC_W-1:0]    duty_step;
    logic [ADC_BITS-1:0] curr_zero;
  } cfg_t;

  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [SUM_W-1:0] d,
                                                   input logic [DUTY_W-1:0] lo,
                                                   input logic [DUTY_W-1:0] hi);
    logic [DUTY_W-1:0] res;
    if (d <= $signed({2'b00, lo})) begin
      res = lo;
    end else if (d >= $signed({2'b00, hi})) begin
      res = hi;
    end else begin
      res = d[DUTY_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [MODE_W-1:0] run_code(input state_t st);
    logic [MODE_W-1:0] code;
    unique case (st)
      ST_IDLE:    code = RUN_IDLE;
      ST_SWEEP:   code = RUN_SWEEP;
      ST_CENTRE:  code = RUN_CENTRE;
      ST_PERTURB: code = RUN_PERTURB;
      default:    code = RUN_IDLE;
    endcase
    return code;
  endfunction

endpackage

### src/mpso_front.sv
// Front end: classifies each accepted word and computes its power.
// Depends on mpso_pkg; feeds mpso_queue.
module mpso_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic                          in_track_enable,
  input  logic [mpso_pkg::ADC_BITS-1:0] in_volt_code,
  input  logic [mpso_pkg::ADC_BITS-1:0] in_curr_code,
  input  logic [mpso_pkg::ADC_BITS-1:0] curr_zero,
  input  logic                          q_full,
  output logic                          push,
  output mpso_pkg::entry_t              push_entry
);

  logic signed [mpso_pkg::PROD_W-1:0] volt_s;
  logic signed [mpso_pkg::PROD_W-1:0] curr_s;
  logic signed [mpso_pkg::PROD_W-1:0] prod;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  assign volt_s = $signed(mpso_pkg::PROD_W'(in_volt_code));
  assign curr_s = $signed(mpso_pkg::PROD_W'(in_curr_code)) -
                  $signed(mpso_pkg::PROD_W'(curr_zero));
  assign prod   = volt_s * curr_s;

  always_comb begin
    if (!in_track_enable) begin
      push_entry.kind = mpso_pkg::KIND_HOLD;
    end else if (in_cmd) begin
      push_entry.kind = mpso_pkg::KIND_START;
    end else begin
      push_entry.kind = mpso_pkg::KIND_SAMPLE;
    end
    if (in_cmd) begin
      push_entry.power = '0;
    end else begin
      push_entry.power = prod[mpso_pkg::PWR_W-1:0];
    end
  end

endmodule

### src/mpso_queue.sv
// Short queue that decouples the front end from the tracking back end.
// Depends on mpso_pkg for the entry type and depth.
module mpso_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mpso_pkg::entry_t push_entry,
  input  logic             pop,
  output mpso_pkg::entry_t head,
  output logic             empty,
  output logic             full
);

  mpso_pkg::entry_t                 mem_r [mpso_pkg::QDEPTH];
  logic [mpso_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [mpso_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [mpso_pkg::QCNT_W-1:0]      count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == mpso_pkg::QCNT_W'(mpso_pkg::QDEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mpso_pkg::QPTR_W'(mpso_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == mpso_pkg::QPTR_W'(mpso_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### src/mpso_back.sv
// Back end: sweep and perturb-and-observe state, duty clamping and the result register.
// Depends on mpso_pkg; takes words from mpso_queue.
module mpso_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpso_pkg::cfg_t                cfg,
  input  mpso_pkg::entry_t              head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mpso_pkg::DUTY_W-1:0]   out_duty_fraction,
  output logic [mpso_pkg::DUTY_W-1:0]   out_compare_value,
  output mpso_pkg::power_t              out_power_measure,
  output logic [mpso_pkg::MODE_W-1:0]   out_run_mode,
  output logic [mpso_pkg::DUTY_W-1:0]   out_best_duty_out
);

  mpso_pkg::state_t               state_r, state_nxt;
  logic [mpso_pkg::DUTY_W-1:0]    duty_r, duty_nxt;
  logic [mpso_pkg::DUTY_W-1:0]    best_duty_r, best_duty_nxt;
  mpso_pkg::power_t               best_power_r, best_power_nxt;
  logic                           perturb_up_r, perturb_up_nxt;
  logic                           out_valid_r;
  logic [mpso_pkg::DUTY_W-1:0]    out_duty_r;
  mpso_pkg::power_t               out_power_r;
  logic [mpso_pkg::MODE_W-1:0]    out_mode_r;
  logic [mpso_pkg::DUTY_W-1:0]    out_best_r;
  logic [mpso_pkg::DUTY_W-1:0]    duty_cur;
  logic [mpso_pkg::DUTY_W-1:0]    best_cand;
  logic signed [mpso_pkg::SUM_W-1:0] inc_s;
  logic signed [mpso_pkg::SUM_W-1:0] target;
  logic [mpso_pkg::CMP_PROD_W-1:0] cmp_prod;

  assign pop       = !empty && (!out_valid_r || out_ready);
  assign inc_s     = $signed(mpso_pkg::SUM_W'(cfg.duty_step));
  assign duty_cur  = mpso_pkg::clamp_duty($signed(mpso_pkg::SUM_W'(duty_r)),
                                          cfg.duty_low, cfg.duty_high);
  assign best_cand = (head.power > best_power_r) ? duty_cur : best_duty_r;

  always_comb begin
    state_nxt      = state_r;
    duty_nxt       = duty_cur;
    best_duty_nxt  = best_duty_r;
    best_power_nxt = best_power_r;
    perturb_up_nxt = perturb_up_r;
    target         = $signed(mpso_pkg::SUM_W'(best_duty_r));
    case (head.kind)
      mpso_pkg::KIND_HOLD: begin
        state_nxt = mpso_pkg::ST_IDLE;
      end
      mpso_pkg::KIND_START: begin
        state_nxt = mpso_pkg::ST_SWEEP;
      end
      mpso_pkg::KIND_SAMPLE: begin
        unique case (state_r)
          mpso_pkg::ST_SWEEP: begin
            if (head.power > best_power_r) begin
              best_power_nxt = head.power;
            end
            best_duty_nxt = best_cand;
            if (duty_cur >= cfg.duty_high) begin
              target    = $signed(mpso_pkg::SUM_W'(best_cand));
              state_nxt = mpso_pkg::ST_CENTRE;
            end else begin
              target = $signed(mpso_pkg::SUM_W'(duty_cur)) + inc_s;
            end
            duty_nxt = mpso_pkg::clamp_duty(target, cfg.duty_low, cfg.duty_high);
          end
          mpso_pkg::ST_CENTRE: begin
            best_power_nxt = head.power;
            if (perturb_up_r) begin
              target = $signed(mpso_pkg::SUM_W'(best_duty_r)) + inc_s;
            end else begin
              target = $signed(mpso_pkg::SUM_W'(best_duty_r)) - inc_s;
            end
            duty_nxt       = mpso_pkg::clamp_duty(target, cfg.duty_low, cfg.duty_high);
            perturb_up_nxt = !perturb_up_r;
            state_nxt      = mpso_pkg::ST_PERTURB;
          end
          mpso_pkg::ST_PERTURB: begin
            if (head.power > best_power_r) begin
              best_power_nxt = head.power;
            end
            best_duty_nxt = best_cand;
            target        = $signed(mpso_pkg::SUM_W'(best_cand));
            duty_nxt      = mpso_pkg::clamp_duty(target, cfg.duty_low, cfg.duty_high);
            state_nxt     = mpso_pkg::ST_CENTRE;
          end
          mpso_pkg::ST_IDLE: begin
            state_nxt = mpso_pkg::ST_IDLE;
          end
          default: begin
            state_nxt = mpso_pkg::ST_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mpso_pkg::ST_IDLE;
      duty_r       <= mpso_pkg::RST_DUTY;
      best_duty_r  <= '0;
      best_power_r <= '0;
      perturb_up_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        state_r      <= state_nxt;
        duty_r       <= duty_nxt;
        best_duty_r  <= best_duty_nxt;
        best_power_r <= best_power_nxt;
        perturb_up_r <= perturb_up_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_duty_r  <= duty_nxt;
      out_power_r <= head.power;
      out_mode_r  <= mpso_pkg::run_code(state_nxt);
      out_best_r  <= best_duty_nxt;
    end
  end

  assign cmp_prod = mpso_pkg::CMP_PROD_W'(mpso_pkg::PWM_PERIOD) *
                    mpso_pkg::CMP_PROD_W'(out_duty_r);

  assign out_valid         = out_valid_r;
  assign out_duty_fraction = out_duty_r;
  assign out_compare_value = cmp_prod[mpso_pkg::CMP_PROD_W-1:mpso_pkg::DUTY_W];
  assign out_power_measure = out_power_r;
  assign out_run_mode      = out_mode_r;
  assign out_best_duty_out = out_best_r;

`ifndef NO_ASSERTIONS
  a_hold_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head.kind == mpso_pkg::KIND_HOLD |=> state_r == mpso_pkg::ST_IDLE)
    else $error("hold word did not return the tracker to idle");

  a_duty_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    pop && cfg.duty_low <= cfg.duty_high |=>
      duty_r >= $past(cfg.duty_low) && duty_r <= $past(cfg.duty_high))
    else $error("commanded duty left the clamp limits");

  a_centre_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head.kind == mpso_pkg::KIND_SAMPLE && state_r == mpso_pkg::ST_CENTRE |=>
      perturb_up_r != $past(perturb_up_r) && state_r == mpso_pkg::ST_PERTURB)
    else $error("centre sample did not flip the perturbation direction");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_duty_r == duty_r && out_best_r == best_duty_r)
    else $error("result word disagrees with tracker state");
`endif

endmodule

### src/mppt_sweep_perturb_observe_core.sv
// Top level of the sweep and perturb-and-observe maximum power point tracker.
// Depends on mpso_pkg, mpso_front, mpso_queue and mpso_back.
//
//   channel  handshake               payload
//   in       in_valid / in_ready     in_cmd, in_track_enable, in_volt_code, in_curr_code
//   out      out_valid / out_ready   out_duty_fraction, out_compare_value,
//                                    out_power_measure, out_run_mode, out_best_duty_out
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word per cycle is sustained while out_ready stays high; an accepted word is written
// into the two-entry queue and popped from its head as the tracking step loads the result
// register.
// The front end stalls only when the queue is full; the back end stalls when a result waits.
// Reset is synchronous and active low and restores all limits and tracker state.
// Configuration writes are always accepted.
module mppt_sweep_perturb_observe_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_cmd,
  input  logic                             in_track_enable,
  input  logic [mpso_pkg::ADC_BITS-1:0]    in_volt_code,
  input  logic [mpso_pkg::ADC_BITS-1:0]    in_curr_code,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mpso_pkg::DUTY_W-1:0]      out_duty_fraction,
  output logic [mpso_pkg::DUTY_W-1:0]      out_compare_value,
  output logic signed [mpso_pkg::PWR_W-1:0] out_power_measure,
  output logic [mpso_pkg::MODE_W-1:0]      out_run_mode,
  output logic [mpso_pkg::DUTY_W-1:0]      out_best_duty_out,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mpso_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpso_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mpso_pkg::cfg_t   cfg_r;
  mpso_pkg::entry_t push_entry;
  mpso_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             q_empty;
  logic             q_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_low  <= mpso_pkg::RST_DUTY_LOW;
      cfg_r.duty_high <= mpso_pkg::RST_DUTY_HIGH;
      cfg_r.duty_step <= mpso_pkg::RST_DUTY_STEP;
      cfg_r.curr_zero <= mpso_pkg::RST_CURR_ZERO;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mpso_pkg::REG_DUTY_LOW:  cfg_r.duty_low  <= cfg_data[mpso_pkg::DUTY_W-1:0];
        mpso_pkg::REG_DUTY_HIGH: cfg_r.duty_high <= cfg_data[mpso_pkg::DUTY_W-1:0];
        mpso_pkg::REG_DUTY_STEP: cfg_r.duty_step <= cfg_data[mpso_pkg::INC_W-1:0];
        mpso_pkg::REG_CURR_ZERO: cfg_r.curr_zero <= cfg_data[mpso_pkg::ADC_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  mpso_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_track_enable (in_track_enable),
    .in_volt_code    (in_volt_code),
    .in_curr_code    (in_curr_code),
    .curr_zero       (cfg_r.curr_zero),
    .q_full          (q_full),
    .push            (push),
    .push_entry      (push_entry)
  );

  mpso_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  mpso_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head              (head),
    .empty             (q_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_duty_fraction (out_duty_fraction),
    .out_compare_value (out_compare_value),
    .out_power_measure (out_power_measure),
    .out_run_mode      (out_run_mode),
    .out_best_duty_out (out_best_duty_out)
  );

endmodule

### dv/tb_mppt_sweep_perturb_observe_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for mppt_sweep_perturb_observe_core with its own tracker model.
// Depends on mpso_pkg and the core RTL; drives random handshakes and configuration phases.
module tb_mppt_sweep_perturb_observe_core;

  localparam int STALL_LIMIT = 400;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 125;

  typedef struct packed {
    logic                          cmd;
    logic                          en;
    logic [mpso_pkg::ADC_BITS-1:0] volt;
    logic [mpso_pkg::ADC_BITS-1:0] curr;
  } sample_t;

  typedef struct packed {
    logic [mpso_pkg::DUTY_W-1:0] duty;
    logic [mpso_pkg::DUTY_W-1:0] compare;
    mpso_pkg::power_t            power;
    logic [mpso_pkg::MODE_W-1:0] mode;
    logic [mpso_pkg::DUTY_W-1:0] best;
  } setpoint_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_cmd = 1'b0;
  logic                              in_track_enable = 1'b0;
  logic [mpso_pkg::ADC_BITS-1:0]     in_volt_code = '0;
  logic [mpso_pkg::ADC_BITS-1:0]     in_curr_code = '0;
  logic                              out_ready = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic [mpso_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [mpso_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
  logic                              in_ready;
  logic                              out_valid;
  logic [mpso_pkg::DUTY_W-1:0]       out_duty_fraction;
  logic [mpso_pkg::DUTY_W-1:0]       out_compare_value;
  logic signed [mpso_pkg::PWR_W-1:0] out_power_measure;
  logic [mpso_pkg::MODE_W-1:0]       out_run_mode;
  logic [mpso_pkg::DUTY_W-1:0]       out_best_duty_out;
  logic                              cfg_ready;

  sample_t   sample_q[$];
  setpoint_t setpoint_q[$];
  int        idle_pct = 25;
  int        mismatch_cnt = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  int        quiet_cycles = 0;

  logic [mpso_pkg::DUTY_W-1:0]   lim_lo = mpso_pkg::RST_DUTY_LOW;
  logic [mpso_pkg::DUTY_W-1:0]   lim_hi = mpso_pkg::RST_DUTY_HIGH;
  logic [mpso_pkg::INC_W-1:0]    step_sz = mpso_pkg::RST_DUTY_STEP;
  logic [mpso_pkg::ADC_BITS-1:0] zero_code = mpso_pkg::RST_CURR_ZERO;
  logic [mpso_pkg::MODE_W-1:0]   mode_q = mpso_pkg::RUN_IDLE;
  logic [mpso_pkg::DUTY_W-1:0]   duty_q = mpso_pkg::RST_DUTY;
  logic [mpso_pkg::DUTY_W-1:0]   best_duty_q = '0;
  mpso_pkg::power_t              best_pwr_q = '0;
  logic                          go_up_q = 1'b0;

  mppt_sweep_perturb_observe_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_track_enable   (in_track_enable),
    .in_volt_code      (in_volt_code),
    .in_curr_code      (in_curr_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_duty_fraction (out_duty_fraction),
    .out_compare_value (out_compare_value),
    .out_power_measure (out_power_measure),
    .out_run_mode      (out_run_mode),
    .out_best_duty_out (out_best_duty_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [mpso_pkg::DUTY_W-1:0] limit_duty(input int d);
    if (d <= int'(lim_lo)) begin
      return lim_lo;
    end
    if (d >= int'(lim_hi)) begin
      return lim_hi;
    end
    return mpso_pkg::DUTY_W'(d);
  endfunction

  function automatic setpoint_t track_step(input sample_t w);
    setpoint_t        r;
    mpso_pkg::power_t raw;
    mpso_pkg::power_t pwr;
    raw = mpso_pkg::power_t'(int'(w.volt) * (int'(w.curr) - int'(zero_code)));
    pwr = '0;
    duty_q = limit_duty(int'(duty_q));
    if (!w.en) begin
      mode_q = mpso_pkg::RUN_IDLE;
      if (!w.cmd) begin
        pwr = raw;
      end
    end else if (w.cmd) begin
      mode_q = mpso_pkg::RUN_SWEEP;
    end else begin
      pwr = raw;
      case (mode_q)
        mpso_pkg::RUN_SWEEP: begin
          if (pwr > best_pwr_q) begin
            best_pwr_q = pwr;
            best_duty_q = duty_q;
          end
          if (duty_q >= lim_hi) begin
            duty_q = limit_duty(int'(best_duty_q));
            mode_q = mpso_pkg::RUN_CENTRE;
          end else begin
            duty_q = limit_duty(int'(duty_q) + int'(step_sz));
          end
        end
        mpso_pkg::RUN_CENTRE: begin
          best_pwr_q = pwr;
          duty_q = limit_duty(int'(best_duty_q) + (go_up_q ? int'(step_sz) : -int'(step_sz)));
          go_up_q = ~go_up_q;
          mode_q = mpso_pkg::RUN_PERTURB;
        end
        mpso_pkg::RUN_PERTURB: begin
          if (pwr > best_pwr_q) begin
            best_pwr_q = pwr;
            best_duty_q = duty_q;
          end
          duty_q = limit_duty(int'(best_duty_q));
          mode_q = mpso_pkg::RUN_CENTRE;
        end
        default: begin
        end
      endcase
    end
    r.duty = duty_q;
    r.compare = mpso_pkg::DUTY_W'((mpso_pkg::PWM_PERIOD * int'(duty_q)) >> 16);
    r.power = pwr;
    r.mode = mode_q;
    r.best = best_duty_q;
    return r;
  endfunction

  task automatic push_word(input int cmd, input int en, input int volt, input int curr);
    sample_q.push_back('{1'(cmd), 1'(en), mpso_pkg::ADC_BITS'(volt),
                         mpso_pkg::ADC_BITS'(curr)});
  endtask

  task automatic write_reg(input logic [mpso_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mpso_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mpso_pkg::REG_DUTY_LOW:  lim_lo = data;
      mpso_pkg::REG_DUTY_HIGH: lim_hi = data;
      mpso_pkg::REG_DUTY_STEP: step_sz = data[mpso_pkg::INC_W-1:0];
      mpso_pkg::REG_CURR_ZERO: zero_code = data[mpso_pkg::ADC_BITS-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    while (sample_q.size() != 0 || in_valid || setpoint_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive
    sample_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        setpoint_q.push_back(track_step({in_cmd, in_track_enable, in_volt_code, in_curr_code}));
      end
      if (!in_valid || in_ready) begin
        if (in_gap == 0 && idle_pct > 0 && $urandom_range(99) < idle_pct) begin
          in_gap = $urandom_range(5, 1);
        end
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          w = sample_q.pop_front();
          in_valid <= 1'b1;
          in_cmd <= w.cmd;
          in_track_enable <= w.en;
          in_volt_code <= w.volt;
          in_curr_code <= w.curr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check
    setpoint_t exp_sp;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (setpoint_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("unexpected result word: duty %0d mode %0d power %0d",
                     out_duty_fraction, out_run_mode, out_power_measure);
          end
        end else begin
          exp_sp = setpoint_q.pop_front();
          if (out_duty_fraction !== exp_sp.duty || out_compare_value !== exp_sp.compare ||
              out_power_measure !== exp_sp.power || out_run_mode !== exp_sp.mode ||
              out_best_duty_out !== exp_sp.best) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch (expected/actual): duty %0d/%0d compare %0d/%0d power %0d/%0d",
                       exp_sp.duty, out_duty_fraction, exp_sp.compare, out_compare_value,
                       exp_sp.power, out_power_measure);
              $display("  mode %0d/%0d best duty %0d/%0d", exp_sp.mode, out_run_mode,
                       exp_sp.best, out_best_duty_out);
            end
          end
        end
      end
      if (out_gap == 0 && idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        out_gap = $urandom_range(5, 1);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_mppt_sweep_perturb_observe_core: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int ph;
    int k;
    int r;
    int lo;
    int hi;
    int span;
    int inc;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    push_word(0, 0, 0, 0);
    push_word(0, 0, 4095, 4095);
    push_word(0, 0, 4095, 0);
    push_word(0, 0, 0, 4095);
    push_word(1, 0, 4095, 4095);
    push_word(0, 1, 100, 3000);
    push_word(1, 1, 0, 0);
    for (k = 0; k < 8; k++) begin
      push_word(0, 1, 2000, (k < 4) ? 1800 + k * 120 : 2700 - k * 120);
    end
    push_word(0, 0, 1000, 2500);
    push_word(1, 1, 4095, 4095);
    for (k = 0; k < 3; k++) begin
      push_word(0, 1, 3000, 3000);
    end
    drain();

    for (ph = 1; ph < PHASES; ph++) begin
      idle_pct = (ph % 3 == 1 || ph == PHASES - 1) ? 0 : 25;
      case (ph)
        1: begin
          write_reg(mpso_pkg::REG_DUTY_LOW, 16'd0);
          write_reg(mpso_pkg::REG_DUTY_HIGH, 16'd65535);
          write_reg(mpso_pkg::REG_DUTY_STEP, 16'd8192);
          write_reg(mpso_pkg::REG_CURR_ZERO, 16'd0);
        end
        2: begin
          write_reg(mpso_pkg::REG_DUTY_LOW, 16'd65535);
          write_reg(mpso_pkg::REG_DUTY_HIGH, 16'd0);
          write_reg(mpso_pkg::REG_DUTY_STEP, 16'd1);
          write_reg(mpso_pkg::REG_CURR_ZERO, 16'd4095);
        end
        3: begin
          write_reg(mpso_pkg::REG_DUTY_LOW, 16'd30000);
          write_reg(mpso_pkg::REG_DUTY_HIGH, 16'd30000);
          write_reg(mpso_pkg::REG_DUTY_STEP, 16'd0);
          write_reg(mpso_pkg::REG_CURR_ZERO, 16'd2048);
        end
        4: begin
          write_reg(mpso_pkg::REG_DUTY_LOW, 16'd1000);
          write_reg(mpso_pkg::REG_DUTY_HIGH, 16'd60000);
          write_reg(mpso_pkg::REG_DUTY_STEP, 16'd0);
          write_reg(mpso_pkg::REG_CURR_ZERO, mpso_pkg::CFG_DATA_W'($urandom));
        end
        default: begin
          lo = $urandom_range(50000);
          span = $urandom_range(15535);
          hi = lo + span;
          inc = span / $urandom_range(30, 3) + 1;
          write_reg(mpso_pkg::REG_DUTY_HIGH, mpso_pkg::CFG_DATA_W'(hi));
          write_reg(mpso_pkg::REG_DUTY_LOW, mpso_pkg::CFG_DATA_W'(lo));
          write_reg(mpso_pkg::REG_DUTY_STEP,
                    {2'($urandom_range(3)), mpso_pkg::INC_W'(inc)});
          write_reg(mpso_pkg::REG_CURR_ZERO,
                    {4'($urandom_range(15)), mpso_pkg::ADC_BITS'($urandom_range(4095))});
        end
      endcase

      push_word(1, 1, $urandom_range(4095), $urandom_range(4095));
      if (ph <= 2) begin
        push_word(0, 1, 4095, 4095);
        push_word(0, 1, 4095, 0);
      end
      for (k = 0; k < PHASE_WORDS; k++) begin
        r = $urandom_range(99);
        if (r < 5) begin
          push_word($urandom_range(1), 0, $urandom_range(4095), $urandom_range(4095));
        end else if (r < 8) begin
          push_word(1, 1, $urandom_range(4095), $urandom_range(4095));
        end else begin
          push_word(0, 1, $urandom_range(4095), $urandom_range(4095));
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb_mppt_sweep_perturb_observe_core: PASS");
    end else begin
      $display("tb_mppt_sweep_perturb_observe_core: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
src/mpso_pkg.sv
src/mpso_front.sv
src/mpso_queue.sv
src/mpso_back.sv
src/mppt_sweep_perturb_observe_core.sv
dv/tb_mppt_sweep_perturb_observe_core.sv
